// ----- rtl/core/hrp_pkg.sv -----
// Package for the HTTP request head parser: item types, parse state,
// event codes, character constants and character-class helpers.
// No dependencies.
`default_nettype none

package hrp_pkg;

  localparam int unsigned MAX_REQUEST_BYTES = 4096;
  localparam int unsigned POS_W = $clog2(MAX_REQUEST_BYTES) + 1;
  localparam int unsigned OFS_W = 12;

  typedef enum logic [4:0] {
    S_START, S_METHOD, S_BEFORE_PATH, S_PATH, S_PARA_START, S_PARA_KEY,
    S_PARA_VSTART, S_PARA_VALUE, S_H, S_HT, S_HTT, S_HTTP, S_SLASH,
    S_VSTART, S_VERSION, S_CR, S_LF, S_LINE_START, S_HKEY, S_HBEFORE,
    S_HVSTART, S_HVALUE, S_HLF, S_FINAL_LF, S_DONE
  } pstate_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_METHOD    = 3'd1,
    EV_PATH      = 3'd2,
    EV_PARAM     = 3'd3,
    EV_HEADER    = 3'd4,
    EV_DONE      = 3'd5,
    EV_INVALID   = 3'd6
  } event_t;

  typedef enum logic {
    M_GET  = 1'b0,
    M_POST = 1'b1
  } method_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7a;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       first_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]       event_res;
    logic             method;
    logic [1:0]       major;
    logic             minor;
    logic [11:0]      version;
    logic [OFS_W-1:0] key_begin;
    logic [OFS_W-1:0] key_end;
    logic [OFS_W-1:0] value_begin;
    logic [OFS_W-1:0] value_end;
    logic             value_present;
    logic [12:0]      body_offset;
  } res_t;

  typedef struct packed {
    pstate_t          st;
    logic [POS_W-1:0] pos;
    logic [2:0]       mlen;
    logic             get_m;
    logic             post_m;
    method_t          meth;
    logic [OFS_W-1:0] tb;
    logic [OFS_W-1:0] tf;
    logic [OFS_W-1:0] vb;
    logic [1:0]       maj;
    logic             mnr;
    logic             halted;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    st: S_START, pos: '0, mlen: '0, get_m: 1'b1, post_m: 1'b1, meth: M_GET,
    tb: '0, tf: '0, vb: '0, maj: '0, mnr: 1'b0, halted: 1'b0
  };

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= CH_UA) && (c <= CH_UZ);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || ((c >= CH_LA) && (c <= CH_LZ));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_key(input logic [7:0] c);
    return is_alpha(c) || (c == CH_DASH) || (c == CH_USCORE);
  endfunction

  function automatic logic is_pval(input logic [7:0] c);
    return is_key(c) || is_digit(c);
  endfunction

  function automatic logic is_path(input logic [7:0] c);
    return is_key(c) || (c == CH_DOT) || (c == CH_SLASH);
  endfunction

  // letter of "GET" at a position, positions 0..2
  function automatic logic [7:0] get_letter(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = CH_G;
      3'd1:    r = CH_E;
      default: r = CH_T;
    endcase
    return r;
  endfunction

  // letter of "POST" at a position, positions 0..3
  function automatic logic [7:0] post_letter(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = CH_P;
      3'd1:    r = CH_O;
      3'd2:    r = CH_S;
      default: r = CH_T;
    endcase
    return r;
  endfunction

  // major * 1000 + minor; fits 12 bits for major <= 3
  function automatic logic [11:0] version_code(input logic [1:0] maj, input logic mnr);
    logic [11:0] base;
    unique case (maj)
      2'd0: base = 12'd0;
      2'd1: base = 12'd1000;
      2'd2: base = 12'd2000;
      2'd3: base = 12'd3000;
    endcase
    return base + {11'd0, mnr};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/http_request_head_parser.sv -----
// Top level of the HTTP request head parser: parse state register,
// step logic (hrp_step) and result output stage (hrp_skid). Uses hrp_pkg.
//
// The block takes one request byte per item and returns exactly one result
// item per byte: an event code (none, method ok, path end, parameter, header,
// done, invalid) with the token offsets that go with it, plus the method and
// version seen so far. A byte with first_byte set restarts parsing at offset
// zero. Any syntax error, a last_byte that ends the buffer before the head is
// complete, or a byte at offset 4096 or beyond gives invalid and holds invalid
// until the next first byte; after done the block reports none. Throughput is
// one byte per clock while req_stall is low: the whole parse step is one
// combinational pass from the state register to the result register. The
// output register plus one skid entry let the block keep taking bytes while
// a result waits; req_stall rises only when both are full, and it is a
// register output.
`default_nettype none

module http_request_head_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  hrp_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output hrp_pkg::res_t res
);
  import hrp_pkg::*;

  parse_t state;
  parse_t state_next;
  res_t   step_res;
  logic   accept;

  assign accept = req_valid && !req_stall;

  // parse step for the byte at the input
  hrp_step u_step (
    .cur_in (state),
    .req    (req),
    .nxt    (state_next),
    .res    (step_res)
  );

  // state moves only on an accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // result register and skid entry
  hrp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (step_res),
    .full      (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

`default_nettype wire

// ----- rtl/core/hrp_step.sv -----
// One parse step: next parse state and result item for one request byte.
// Purely combinational. Depends on hrp_pkg.
`default_nettype none

module hrp_step (
  input  hrp_pkg::parse_t cur_in,
  input  hrp_pkg::req_t   req,
  output hrp_pkg::parse_t nxt,
  output hrp_pkg::res_t   res
);
  import hrp_pkg::*;

  parse_t           cur;
  logic [7:0]       c;
  logic             bad;
  event_t           ev;
  logic [OFS_W-1:0] ks, ke, vs, ve, p12;
  logic             vp;
  logic [12:0]      bo;

  assign c   = req.byte_in;
  assign cur = req.first_byte ? PARSE_RESET : cur_in;
  assign p12 = cur.pos[OFS_W-1:0];

  always_comb begin
    nxt = cur;
    bad = 1'b0;
    ev  = EV_NONE;
    ks  = '0;
    ke  = '0;
    vs  = '0;
    ve  = '0;
    vp  = 1'b0;
    bo  = '0;
    priority if (cur.halted) begin
      bad = 1'b1;
    end else if (cur.st == S_DONE) begin
      ev = EV_NONE;
    end else if (cur.pos >= POS_W'(MAX_REQUEST_BYTES)) begin
      bad = 1'b1;
    end else begin
      unique case (cur.st)
        S_START: begin
          if (!is_upper(c)) bad = 1'b1;
          else begin
            nxt.mlen   = 3'd1;
            nxt.get_m  = (c == CH_G);
            nxt.post_m = (c == CH_P);
            nxt.st     = S_METHOD;
          end
        end
        S_METHOD: begin
          if (c == CH_SPACE) begin
            priority if (cur.mlen >= 3'd3 && cur.get_m) begin
              nxt.meth = M_GET;
              ev = EV_METHOD;
              nxt.st = S_BEFORE_PATH;
            end else if (cur.mlen >= 3'd4 && cur.post_m) begin
              nxt.meth = M_POST;
              ev = EV_METHOD;
              nxt.st = S_BEFORE_PATH;
            end else begin
              bad = 1'b1;
            end
          end else if (is_upper(c)) begin
            if (cur.mlen < 3'd3 && c != get_letter(cur.mlen)) nxt.get_m = 1'b0;
            if (cur.mlen < 3'd4 && c != post_letter(cur.mlen)) nxt.post_m = 1'b0;
            if (cur.mlen < 3'd7) nxt.mlen = cur.mlen + 3'd1;
          end else begin
            bad = 1'b1;
          end
        end
        S_BEFORE_PATH: begin
          if (c != CH_SLASH) bad = 1'b1;
          else begin
            nxt.tb = p12;
            nxt.st = S_PATH;
          end
        end
        S_PATH: begin
          if (c == CH_SPACE || c == CH_QUEST) begin
            ev = EV_PATH;
            ks = cur.tb;
            ke = p12;
            nxt.st = (c == CH_SPACE) ? S_H : S_PARA_START;
          end else if (!is_path(c)) bad = 1'b1;
        end
        S_PARA_START: begin
          if (c == CH_SPACE) nxt.st = S_H;
          else if (is_key(c)) begin
            nxt.tb = p12;
            nxt.st = S_PARA_KEY;
          end else bad = 1'b1;
        end
        S_PARA_KEY: begin
          if (c == CH_EQ) begin
            nxt.tf = p12;
            nxt.st = S_PARA_VSTART;
          end else if (c == CH_AMP || c == CH_SPACE) begin
            ev = EV_PARAM;
            ks = cur.tb;
            ke = p12;
            nxt.st = (c == CH_SPACE) ? S_H : S_PARA_START;
          end else if (!is_key(c)) bad = 1'b1;
        end
        S_PARA_VSTART: begin
          if (c == CH_SPACE) begin
            ev = EV_PARAM;
            ks = cur.tb;
            ke = cur.tf;
            nxt.st = S_H;
          end else if (is_pval(c)) begin
            nxt.vb = p12;
            nxt.st = S_PARA_VALUE;
          end else bad = 1'b1;
        end
        S_PARA_VALUE: begin
          if (c == CH_SPACE || c == CH_AMP) begin
            ev = EV_PARAM;
            ks = cur.tb;
            ke = cur.tf;
            vs = cur.vb;
            ve = p12;
            vp = 1'b1;
            nxt.st = (c == CH_SPACE) ? S_H : S_PARA_START;
          end else if (!is_pval(c)) bad = 1'b1;
        end
        S_H:     if (c != CH_H) bad = 1'b1; else nxt.st = S_HT;
        S_HT:    if (c != CH_T) bad = 1'b1; else nxt.st = S_HTT;
        S_HTT:   if (c != CH_T) bad = 1'b1; else nxt.st = S_HTTP;
        S_HTTP:  if (c != CH_P) bad = 1'b1; else nxt.st = S_SLASH;
        S_SLASH: if (c != CH_SLASH) bad = 1'b1; else nxt.st = S_VSTART;
        S_VSTART: begin
          if (c < CH_1 || c > CH_3) bad = 1'b1;
          else begin
            nxt.maj = c[1:0];   // '1'..'3' carry the digit in the low bits
            nxt.st  = S_VERSION;
          end
        end
        S_VERSION: begin
          if (c == CH_DOT) begin
            nxt.st = S_VERSION;
          end else if (c == CH_0 || c == CH_1) begin
            nxt.mnr = c[0];
            nxt.st  = S_CR;
          end else bad = 1'b1;
        end
        S_CR:    if (c != CH_CR) bad = 1'b1; else nxt.st = S_LF;
        S_LF:    if (c != CH_LF) bad = 1'b1; else nxt.st = S_LINE_START;
        S_LINE_START: begin
          if (c == CH_CR) nxt.st = S_FINAL_LF;
          else if (is_key(c)) begin
            nxt.tb = p12;
            nxt.st = S_HKEY;
          end else bad = 1'b1;
        end
        S_HKEY: begin
          if (c == CH_COLON) begin
            nxt.tf = p12;
            nxt.st = S_HBEFORE;
          end else if (!is_key(c)) bad = 1'b1;
        end
        S_HBEFORE: if (c != CH_SPACE) bad = 1'b1; else nxt.st = S_HVSTART;
        S_HVSTART: begin
          if (c == CH_CR || c == CH_LF) bad = 1'b1;
          else begin
            nxt.vb = p12;
            nxt.st = S_HVALUE;
          end
        end
        S_HVALUE: begin
          if (c == CH_CR) begin
            ev = EV_HEADER;
            ks = cur.tb;
            ke = cur.tf;
            vs = cur.vb;
            ve = p12;
            vp = 1'b1;
            nxt.st = S_HLF;
          end else if (c == CH_LF) bad = 1'b1;
        end
        S_HLF:   if (c != CH_LF) bad = 1'b1; else nxt.st = S_LINE_START;
        S_FINAL_LF: begin
          if (c != CH_LF) bad = 1'b1;
          else begin
            ev = EV_DONE;
            bo = 13'(cur.pos + POS_W'(1));
            nxt.st = S_DONE;
          end
        end
        default: bad = 1'b1;
      endcase
      // buffer ran out before the head was complete
      if (!bad && nxt.st != S_DONE && req.last_byte) bad = 1'b1;
    end

    if (bad) begin
      nxt.halted = 1'b1;
      ev = EV_INVALID;
      ks = '0;
      ke = '0;
      vs = '0;
      ve = '0;
      vp = 1'b0;
      bo = '0;
    end
    // offset saturates at the size limit
    if (cur.pos < POS_W'(MAX_REQUEST_BYTES)) nxt.pos = cur.pos + POS_W'(1);
  end

  always_comb begin
    res.event_res     = ev;
    res.method        = nxt.meth;
    res.major         = nxt.maj;
    res.minor         = nxt.mnr;
    res.version       = (nxt.st > S_VERSION) ? version_code(nxt.maj, nxt.mnr) : 12'd0;
    res.key_begin     = ks;
    res.key_end       = ke;
    res.value_begin   = vs;
    res.value_end     = ve;
    res.value_present = vp;
    res.body_offset   = bo;
  end

endmodule

`default_nettype wire

// ----- rtl/core/hrp_skid.sv -----
// Output register with one skid entry for the result channel.
// Depends on hrp_pkg for the result item type.
`default_nettype none

module hrp_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hrp_pkg::res_t push_data,
  output logic          full,
  output logic          res_valid,
  input  logic          res_stall,
  output hrp_pkg::res_t res
);
  import hrp_pkg::*;

  logic skid_valid;
  res_t skid_data;
  logic take;

  assign take = res_valid && !res_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (take) begin
        if (skid_valid) begin
          res        <= skid_data;
          skid_valid <= 1'b0;
        end else if (push) begin
          res <= push_data;
        end else begin
          res_valid <= 1'b0;
        end
      end else if (push) begin
        if (!res_valid) begin
          res       <= push_data;
          res_valid <= 1'b1;
        end else begin
          skid_data  <= push_data;
          skid_valid <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hrp_checker.sv -----
// Port-level checks for the HTTP request head parser, bound to the top level.
// Depends on hrp_pkg and http_request_head_parser.
`default_nettype none

module hrp_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input hrp_pkg::req_t req,
  input logic          res_valid,
  input logic          res_stall,
  input hrp_pkg::res_t res
);
  import hrp_pkg::*;

  // a stalled result stays put
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // every accepted byte has a result pending on the next cycle
  a_res_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> res_valid)
    else $error("accepted byte left no result");

  // body offset is given on done and only on done
  a_body_offset: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.event_res == EV_DONE) == (res.body_offset != 13'd0)))
    else $error("body offset does not match done event");

  // invalid carries no token offsets
  a_invalid_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == EV_INVALID |->
      res.key_begin == 12'd0 && res.value_end == 12'd0 && !res.value_present)
    else $error("invalid result carries offsets");

  // a version is only reported once a major digit is known
  a_version_major: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.version != 12'd0 |-> res.major != 2'd0)
    else $error("version without major digit");

endmodule

bind http_request_head_parser hrp_checker u_hrp_checker (.*);

`default_nettype wire

// ----- tb/http_request_head_parser_tb.sv -----
// Self-checking testbench for http_request_head_parser: directed and random
// request streams, with a local parse predictor checked against every result.
// Depends on hrp_pkg and the http_request_head_parser RTL only.

module http_request_head_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hrp_pkg::*;

  typedef logic [7:0] text_q_t[$];

  // a run of this many cycles with no item moving on either side is a hang
  localparam int QUIET_LIMIT = 2000;
  localparam logic [23:0] GET_TEXT  = "GET";
  localparam logic [31:0] POST_TEXT = "POST";

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic res_valid;
  logic res_stall;
  res_t res;

  http_request_head_parser dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // one expected result per accepted byte, oldest first
  res_t pending_events[$];
  int   mismatch_count = 0;
  int   bytes_sent = 0;

  // idle control: random gaps per item on each side, plus one long receiver
  // hold-off that the backpressure test arms
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;
  int   rx_hold_cycles = 0;

  // ---------------------------------------------------------------------------
  // Parse predictor: its own copy of the head parser state
  // ---------------------------------------------------------------------------
  pstate_t          ps;
  logic [POS_W-1:0] byte_pos;
  logic [2:0]       meth_len;
  logic             get_ok;
  logic             post_ok;
  method_t          cur_method;
  logic [11:0]      tok_start;
  logic [11:0]      tok_stop;
  logic [11:0]      val_start;
  logic [1:0]       maj_digit;
  logic             min_digit;
  logic             stuck;

  function automatic void restart_parse();
    ps         = S_START;
    byte_pos   = '0;
    meth_len   = '0;
    get_ok     = 1'b1;
    post_ok    = 1'b1;
    cur_method = M_GET;
    tok_start  = '0;
    tok_stop   = '0;
    val_start  = '0;
    maj_digit  = '0;
    min_digit  = 1'b0;
    stuck      = 1'b0;
  endfunction

  function automatic bit ch_upper(input logic [7:0] c);
    return c >= CH_UA && c <= CH_UZ;
  endfunction

  function automatic bit ch_keyword(input logic [7:0] c);
    return ch_upper(c) || (c >= CH_LA && c <= CH_LZ) || c == CH_DASH || c == CH_USCORE;
  endfunction

  function automatic bit ch_param_val(input logic [7:0] c);
    return ch_keyword(c) || (c >= CH_0 && c <= CH_9);
  endfunction

  function automatic bit ch_path(input logic [7:0] c);
    return ch_keyword(c) || c == CH_DOT || c == CH_SLASH;
  endfunction

  // advance the predictor by one byte and return the event it should give
  function automatic res_t parse_byte(input req_t r);
    res_t        e;
    logic        bad;
    logic [7:0]  c;
    logic [11:0] p12;
    int          mi;
    e   = '0;
    bad = 1'b0;
    c   = r.byte_in;
    if (r.first_byte) restart_parse();
    p12 = byte_pos[11:0];
    mi  = int'(meth_len);
    if (stuck) begin
      bad = 1'b1;
    end else if (ps == S_DONE) begin
      e.event_res = EV_NONE;
    end else if (byte_pos >= MAX_REQUEST_BYTES) begin
      bad = 1'b1;
    end else begin
      case (ps)
        S_START: begin
          if (!ch_upper(c)) bad = 1'b1;
          else begin
            meth_len = 3'd1;
            get_ok   = (c == GET_TEXT[23:16]);
            post_ok  = (c == POST_TEXT[31:24]);
            ps       = S_METHOD;
          end
        end
        S_METHOD: begin
          if (c == CH_SPACE) begin
            // GET wins when both prefixes could match
            if (meth_len >= 3 && get_ok) cur_method = M_GET;
            else if (meth_len >= 4 && post_ok) cur_method = M_POST;
            else bad = 1'b1;
            if (!bad) begin
              e.event_res = EV_METHOD;
              ps = S_BEFORE_PATH;
            end
          end else if (ch_upper(c)) begin
            if (mi < 3 && c != GET_TEXT[8*(2-mi) +: 8]) get_ok = 1'b0;
            if (mi < 4 && c != POST_TEXT[8*(3-mi) +: 8]) post_ok = 1'b0;
            if (mi < 7) meth_len = meth_len + 3'd1;
          end else begin
            bad = 1'b1;
          end
        end
        S_BEFORE_PATH: begin
          if (c != CH_SLASH) bad = 1'b1;
          else begin
            tok_start = p12;
            ps = S_PATH;
          end
        end
        S_PATH: begin
          if (c == CH_SPACE || c == CH_QUEST) begin
            e.event_res = EV_PATH;
            e.key_begin = tok_start;
            e.key_end   = p12;
            ps = (c == CH_SPACE) ? S_H : S_PARA_START;
          end else if (!ch_path(c)) begin
            bad = 1'b1;
          end
        end
        S_PARA_START: begin
          if (c == CH_SPACE) ps = S_H;
          else if (ch_keyword(c)) begin
            tok_start = p12;
            ps = S_PARA_KEY;
          end else bad = 1'b1;
        end
        S_PARA_KEY: begin
          if (c == CH_EQ) begin
            tok_stop = p12;
            ps = S_PARA_VSTART;
          end else if (c == CH_AMP || c == CH_SPACE) begin
            e.event_res = EV_PARAM;
            e.key_begin = tok_start;
            e.key_end   = p12;
            ps = (c == CH_SPACE) ? S_H : S_PARA_START;
          end else if (!ch_keyword(c)) begin
            bad = 1'b1;
          end
        end
        S_PARA_VSTART: begin
          // key with '=' but no value: reported without a value
          if (c == CH_SPACE) begin
            e.event_res = EV_PARAM;
            e.key_begin = tok_start;
            e.key_end   = tok_stop;
            ps = S_H;
          end else if (ch_param_val(c)) begin
            val_start = p12;
            ps = S_PARA_VALUE;
          end else bad = 1'b1;
        end
        S_PARA_VALUE: begin
          if (c == CH_SPACE || c == CH_AMP) begin
            e.event_res     = EV_PARAM;
            e.key_begin     = tok_start;
            e.key_end       = tok_stop;
            e.value_begin   = val_start;
            e.value_end     = p12;
            e.value_present = 1'b1;
            ps = (c == CH_SPACE) ? S_H : S_PARA_START;
          end else if (!ch_param_val(c)) begin
            bad = 1'b1;
          end
        end
        S_H:     if (c != CH_H) bad = 1'b1; else ps = S_HT;
        S_HT:    if (c != CH_T) bad = 1'b1; else ps = S_HTT;
        S_HTT:   if (c != CH_T) bad = 1'b1; else ps = S_HTTP;
        S_HTTP:  if (c != CH_P) bad = 1'b1; else ps = S_SLASH;
        S_SLASH: if (c != CH_SLASH) bad = 1'b1; else ps = S_VSTART;
        S_VSTART: begin
          if (c < CH_1 || c > CH_3) bad = 1'b1;
          else begin
            maj_digit = 2'(c - CH_0);
            ps = S_VERSION;
          end
        end
        S_VERSION: begin
          // any number of dots before the minor digit
          if (c == CH_DOT) ;
          else if (c == CH_0 || c == CH_1) begin
            min_digit = c[0];
            ps = S_CR;
          end else bad = 1'b1;
        end
        S_CR: if (c != CH_CR) bad = 1'b1; else ps = S_LF;
        S_LF: if (c != CH_LF) bad = 1'b1; else ps = S_LINE_START;
        S_LINE_START: begin
          if (c == CH_CR) ps = S_FINAL_LF;
          else if (ch_keyword(c)) begin
            tok_start = p12;
            ps = S_HKEY;
          end else bad = 1'b1;
        end
        S_HKEY: begin
          if (c == CH_COLON) begin
            tok_stop = p12;
            ps = S_HBEFORE;
          end else if (!ch_keyword(c)) begin
            bad = 1'b1;
          end
        end
        S_HBEFORE: if (c != CH_SPACE) bad = 1'b1; else ps = S_HVSTART;
        S_HVSTART: begin
          if (c == CH_CR || c == CH_LF) bad = 1'b1;
          else begin
            val_start = p12;
            ps = S_HVALUE;
          end
        end
        S_HVALUE: begin
          if (c == CH_CR) begin
            e.event_res     = EV_HEADER;
            e.key_begin     = tok_start;
            e.key_end       = tok_stop;
            e.value_begin   = val_start;
            e.value_end     = p12;
            e.value_present = 1'b1;
            ps = S_HLF;
          end else if (c == CH_LF) begin
            bad = 1'b1;
          end
        end
        S_HLF: if (c != CH_LF) bad = 1'b1; else ps = S_LINE_START;
        S_FINAL_LF: begin
          if (c != CH_LF) bad = 1'b1;
          else begin
            e.event_res   = EV_DONE;
            e.body_offset = 13'(byte_pos + 13'd1);
            ps = S_DONE;
          end
        end
        default: bad = 1'b1;
      endcase
      // buffer ran out before the head was complete
      if (!bad && ps != S_DONE && r.last_byte) bad = 1'b1;
    end

    if (bad) begin
      stuck = 1'b1;
      e = '0;
      e.event_res = EV_INVALID;
    end
    if (byte_pos < MAX_REQUEST_BYTES) byte_pos = byte_pos + 1'b1;

    e.method = cur_method;
    e.major  = maj_digit;
    e.minor  = min_digit;
    e.version = (ps > S_VERSION && ps <= S_DONE) ?
                12'(int'(maj_digit) * 1000 + int'(min_digit)) : 12'd0;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Request text helpers
  // ---------------------------------------------------------------------------

  // '~' in directed text stands for a CR LF pair
  function automatic void add_text(ref text_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == "~") begin
        q.push_back(CH_CR);
        q.push_back(CH_LF);
      end else begin
        q.push_back(s[i]);
      end
    end
  endfunction

  function automatic logic [7:0] key_char();
    case ($urandom_range(0, 5))
      0, 1:    return 8'($urandom_range(CH_UA, CH_UZ));
      2, 3:    return 8'($urandom_range(CH_LA, CH_LZ));
      4:       return CH_DASH;
      default: return CH_USCORE;
    endcase
  endfunction

  // any byte that does not end a header value
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // well-formed request head with random content; odd methods included
  function automatic text_q_t random_request();
    text_q_t q;
    int      nparam;
    case ($urandom_range(0, 7))
      0, 1, 2: add_text(q, "GET");
      3, 4:    add_text(q, "POST");
      5: begin
        if ($urandom_range(0, 1)) add_text(q, "GET");
        else add_text(q, "POST");
        repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(CH_UA, CH_UZ)));
      end
      default: repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(CH_UA, CH_UZ)));
    endcase
    add_text(q, " /");
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 3) == 0) q.push_back($urandom_range(0, 1) ? CH_DOT : CH_SLASH);
      else q.push_back(key_char());
    end
    if ($urandom_range(0, 2) == 0) begin
      q.push_back(CH_QUEST);
      nparam = $urandom_range(0, 3);
      for (int i = 0; i < nparam; i++) begin
        if (i > 0) q.push_back(CH_AMP);
        repeat ($urandom_range(1, 4)) q.push_back(key_char());
        case ($urandom_range(0, 2))
          0: ;
          1: q.push_back(CH_EQ);
          default: begin
            q.push_back(CH_EQ);
            repeat ($urandom_range(1, 4)) begin
              if ($urandom_range(0, 2) == 0) q.push_back(8'($urandom_range(CH_0, CH_9)));
              else q.push_back(key_char());
            end
          end
        endcase
      end
    end
    add_text(q, " HTTP/");
    q.push_back(8'(CH_0 + $urandom_range(1, 3)));
    repeat ($urandom_range(0, 2)) q.push_back(CH_DOT);
    q.push_back(8'(CH_0 + $urandom_range(0, 1)));
    add_text(q, "~");
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 5)) q.push_back(key_char());
      add_text(q, ": ");
      repeat ($urandom_range(1, 6)) q.push_back(text_byte());
      add_text(q, "~");
    end
    add_text(q, "~");
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // offer one byte, hold it until taken, then record what it should produce
  task automatic send_byte(input logic [7:0] b, input bit f, input bit l);
    req_t item;
    int   gap;
    item.byte_in    = b;
    item.first_byte = f;
    item.last_byte  = l;
    gap = tx_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_events.push_back(parse_byte(item));
    bytes_sent++;
  endtask

  // fresh: first_byte on the opening byte; end_last: last_byte on the final one
  task automatic send_text(input text_q_t q, input bit fresh, input bit end_last);
    foreach (q[i]) send_byte(q[i], fresh && i == 0, end_last && i == q.size() - 1);
  endtask

  task automatic send_msg(input string s, input bit fresh = 1'b1, input bit end_last = 1'b0);
    text_q_t q;
    add_text(q, s);
    send_text(q, fresh, end_last);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver and checker
  // ---------------------------------------------------------------------------
  task automatic cmp_field(input string name, input logic [12:0] want, input logic [12:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic check_event(input res_t got);
    res_t want;
    if (pending_events.size() == 0) begin
      $error("result with no byte pending: event_res %0d", got.event_res);
      mismatch_count++;
    end else begin
      want = pending_events.pop_front();
      cmp_field("event_res", 13'(want.event_res), 13'(got.event_res));
      cmp_field("method", 13'(want.method), 13'(got.method));
      cmp_field("major", 13'(want.major), 13'(got.major));
      cmp_field("minor", 13'(want.minor), 13'(got.minor));
      cmp_field("version", 13'(want.version), 13'(got.version));
      cmp_field("key_begin", 13'(want.key_begin), 13'(got.key_begin));
      cmp_field("key_end", 13'(want.key_end), 13'(got.key_end));
      cmp_field("value_begin", 13'(want.value_begin), 13'(got.value_begin));
      cmp_field("value_end", 13'(want.value_end), 13'(got.value_end));
      cmp_field("value_present", 13'(want.value_present), 13'(got.value_present));
      cmp_field("body_offset", want.body_offset, got.body_offset);
    end
  endtask

  // takes results; draws a stall of random length after each item while rx_idle_on
  // is set, and honors the long hold-off when one is armed
  initial begin : receiver
    int gap_left;
    gap_left = 0;
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        check_event(res);
        gap_left = rx_idle_on ? $urandom_range(0, 3) : 0;
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        res_stall <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // hang detector: counts cycles in which no item moves on either side
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("http_request_head_parser_tb: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // method prefixes: GET checked first, POST next, anything else rejected
  task automatic test_methods();
    send_msg("GET / HTTP/1.1~~", 1'b1, 1'b1);   // last_byte on the done byte is fine
    send_msg("POST /x HTTP/1.0~~");
    send_msg("GETPOST /a HTTP/2.1~~");
    send_msg("POSTAL /b HTTP/3..0~~");
    send_msg("PUT / HTTP/1.1~~");
    send_msg("GE / HTTP/1.1~~");
    send_msg("POS /");
    send_msg("get /");
    send_msg("ZZZZZZZZZZ / HTTP/1.1~~");       // method length saturates
  endtask

  task automatic test_path_params();
    send_msg("GET /a-b_c.d/E?k=v1&flag&e=&Zz=9_- HTTP/1.1~~");
    send_msg("POST /? HTTP/2.0~~");
    send_msg("GET /p?a= HTTP/1.1~~");
    send_msg("GET /p?a HTTP/1.1~~");
    send_msg("GET /p?a& HTTP/1.1~~");
    send_msg("GET p HTTP/1.1~~");
    send_msg("GET /a%b HTTP/1.1~~");
    send_msg("GET /a?=x HTTP/1.1~~");
    send_msg("GET /a?k=v=w HTTP/1.1~~");
    send_msg("GET /a?k=. HTTP/1.1~~");
  endtask

  task automatic test_headers();
    text_q_t q;
    // bytes after done report nothing
    send_msg("GET /h HTTP/1.1~Host: a:b c~X-Y_z: 1~~body", 1'b1, 1'b1);
    add_text(q, "POST /up HTTP/1.1~Bin: ");
    q.push_back(8'h00);
    q.push_back(8'h7f);
    q.push_back(8'h80);
    q.push_back(8'hff);
    add_text(q, "~~");
    send_text(q, 1'b1, 1'b0);
    send_msg("GET / HTTP/1.1~Host:x~~");
    send_msg("GET / HTTP/1.1~Host: ~~");
    q.delete();
    add_text(q, "GET / HTTP/1.1~K: a");
    q.push_back(CH_LF);
    add_text(q, "b~~");
    send_text(q, 1'b1, 1'b0);
    send_msg("GET / HTTP/1.1~K~~");
    send_msg("GET / HTTP/4.1~~");
    send_msg("GET / HTTP/1.2~~");
    send_msg("GET / HTTP/1.1~~");
    send_msg("GET / HTTP/1.1~");
    send_msg("x", 1'b0, 1'b0);                  // continues the previous request with the start of a header key
    send_msg("GET / HTTQ/1.1~~");
  endtask

  task automatic test_buffer_end();
    send_msg("GET / HTTP/1.1~", 1'b1, 1'b1);    // ends right before the empty line
    send_msg("G", 1'b1, 1'b1);
    send_msg("xyz", 1'b0, 1'b1);                // still halted
    send_msg("GET /abc");                        // abandoned mid-request
    send_msg("POST / HTTP/1.1~~", 1'b1, 1'b1);
  endtask

  // receiver holds off long enough for the block to stall its input, then
  // the sender pauses until everything has come back
  task automatic test_backpressure();
    rx_hold_cycles = 80;
    repeat (3) send_text(random_request(), 1'b1, 1'b0);
    wait_for_drain();
    send_msg("GET /after?x=1 HTTP/1.1~A: b~~", 1'b1, 1'b1);
  endtask

  // random requests until the whole run has sent about 1900 bytes
  task automatic test_random_traffic();
    text_q_t q;
    int      kind;
    bit      end_last;
    while (bytes_sent < 1900) begin
      // switch idling on and off now and then for gap-free stretches
      if ($urandom_range(0, 7) == 0) tx_idle_on = !tx_idle_on;
      if ($urandom_range(0, 7) == 0) rx_idle_on = !rx_idle_on;
      kind = $urandom_range(0, 9);
      q = random_request();
      end_last = 1'($urandom_range(0, 1));
      case (kind)
        0: begin
          // raw noise, sometimes continuing whatever came before
          q.delete();
          repeat ($urandom_range(1, 8)) q.push_back(8'($urandom));
          send_text(q, 1'($urandom_range(0, 1)), end_last);
        end
        1: begin
          q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
          send_text(q, 1'b1, end_last);
        end
        2: begin
          q = q[0:$urandom_range(0, q.size() - 1)];
          send_text(q, 1'b1, 1'b1);
        end
        default: begin
          repeat ($urandom_range(0, 3)) q.push_back(8'($urandom));
          send_text(q, 1'b1, end_last);
        end
      endcase
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    restart_parse();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_methods();
    test_path_params();
    test_headers();
    test_buffer_end();
    test_backpressure();
    test_random_traffic();

    // leave room for stray results
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("http_request_head_parser_tb: done, clean");
    end else begin
      $display("http_request_head_parser_tb: done, errors");
    end
    $finish;
  end

endmodule
